@@ rtl/ptw_pkg.sv @@
`default_nettype none

package ptw_pkg;

    localparam int PA_W = 52;
    localparam int VA_W = 48;
    localparam int PTE_W = 64;

    localparam logic [PA_W-1:0] FRAME_MASK = 52'hFFFFFFFFFF000;
    localparam logic [VA_W-1:0] OFFSET_1G = 48'h00003FFFFFFF;
    localparam logic [VA_W-1:0] OFFSET_2M = 48'h0000001FFFFF;
    localparam logic [VA_W-1:0] OFFSET_4K = 48'h000000000FFF;
    localparam int SIZE_BIT = 7;

    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_RESPONSE  = 1'b1;
    localparam logic KIND_READ     = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_1G   = 2'd1;
    localparam logic [1:0] LVL_2M   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic             action;
        logic [VA_W-1:0]  virt_addr;
        logic [PTE_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic            kind;
        logic [PA_W-1:0] read_address;
        logic [PA_W-1:0] physical_address;
        logic            fault;
        logic [1:0]      fault_level;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/ptw_core.sv @@
`default_nettype none

module ptw_core import ptw_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire t_in_item        i_item,
    input  wire logic [PA_W-1:0] i_root,
    output logic                 o_res_valid,
    output t_out_item            o_res
);

    logic            r_busy, n_busy;
    logic [1:0]      r_level, n_level;
    logic [VA_W-1:0] r_vaddr, n_vaddr;

    // index bits of va for a level, scaled to an 8-byte entry offset
    function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] table_base,
                                                   input logic [VA_W-1:0] va,
                                                   input logic [1:0]      lvl);
        logic [8:0] idx;
        unique case (lvl)
            LVL_TOP:  idx = va[47:39];
            LVL_1G:   idx = va[38:30];
            LVL_2M:   idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return (table_base & FRAME_MASK) + {{(PA_W-12){1'b0}}, idx, 3'b000};
    endfunction

    always_comb begin
        logic [PA_W-1:0] entry52;
        logic            big;
        logic [VA_W-1:0] offmask;
        logic [1:0]      lvl_inc;
        entry52 = i_item.read_data[PA_W-1:0];
        big     = i_item.read_data[SIZE_BIT];
        lvl_inc = r_level + 2'd1;
        offmask = OFFSET_4K;
        n_busy  = r_busy;
        n_level = r_level;
        n_vaddr = r_vaddr;
        o_res_valid = 1'b0;
        o_res   = '0;
        if (i_accept) begin
            if (i_item.action == ACT_TRANSLATE) begin
                if (!r_busy) begin
                    n_vaddr = i_item.virt_addr;
                    n_level = LVL_TOP;
                    n_busy  = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_READ;
                    o_res.read_address = entry_addr(i_root, i_item.virt_addr, LVL_TOP);
                end
            end else if (r_busy) begin
                o_res_valid = 1'b1;
                if (i_item.read_data == '0) begin
                    o_res.kind        = KIND_DONE;
                    o_res.fault       = 1'b1;
                    o_res.fault_level = r_level;
                    n_busy  = 1'b0;
                    n_level = LVL_TOP;
                end else if ((r_level == LVL_1G && big) || (r_level == LVL_2M && big)
                             || r_level == LVL_LEAF) begin
                    if (r_level == LVL_1G) offmask = OFFSET_1G;
                    else if (r_level == LVL_2M) offmask = OFFSET_2M;
                    o_res.kind = KIND_DONE;
                    o_res.physical_address = (entry52 & FRAME_MASK)
                        + {{(PA_W-VA_W){1'b0}}, r_vaddr & offmask};
                    n_busy  = 1'b0;
                    n_level = LVL_TOP;
                end else begin
                    n_level = lvl_inc;
                    o_res.kind = KIND_READ;
                    o_res.read_address = entry_addr(entry52, r_vaddr, lvl_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= LVL_TOP;
            r_vaddr <= '0;
        end else begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_vaddr <= n_vaddr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ptw_out_buf.sv @@
`default_nettype none

module ptw_out_buf import ptw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_wr,
    input  wire t_out_item i_data,
    output logic          o_full,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_wr;
            end else begin
                r_out_valid  <= i_wr;
            end
        end else if (i_wr) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out  <= i_data;
            end
        end else if (i_wr) begin
            r_skid <= i_data;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/page_table_walker.sv @@
`default_nettype none
// Four-level page table walker.
// Input channel (i_in_valid / o_in_stall, payload i_in_item) carries two kinds of
// transaction: a translate request with a virtual address, or a memory read
// response with a 64-bit table entry. Output channel (o_out_valid / i_out_stall,
// payload o_out_item) carries either a memory read request for the next entry
// or a finished translation (physical address, or fault with its level).
// Requests while a walk is open and responses while idle produce nothing.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes the root table
// base; ready is always high. Write only while idle.
// A result is registered: into the output register, or the skid while held.
// Throughput: one input transaction per cycle unless the skid is full; the step
// logic is a single mask/shift/add between the walk state registers and the
// output register. Memory latency between responses sets the real walk pace.
// Reset (synchronous, active low) makes the walker idle, level 0, root base 0,
// output empty.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; o_in_stall rises only while that skid is full.
module page_table_walker import ptw_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_item        i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out_item,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [PA_W-1:0] i_cfg_data
);

    logic [PA_W-1:0] r_root;
    logic            accept;
    logic            res_valid;
    t_out_item       res;
    logic            buf_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_valid) begin
            r_root <= i_cfg_data;
        end
    end

    // take a transaction whenever the skid has room
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    ptw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_root      (r_root),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ptw_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (res_valid),
        .i_data      (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ sim/ptw_checker.sv @@
module ptw_checker import ptw_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_stall,
    input  t_in_item             i_in_item,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_stall,
    input  t_out_item            i_out_item,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_ready,
    input  wire logic [PA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the walker state
    logic [PA_W-1:0] root_base;
    logic            walk_open;
    logic [1:0]      walk_depth;
    logic [VA_W-1:0] walk_vaddr;

    // Reads and translations the walker still owes us, oldest first
    t_out_item walker_replies[$];

    function automatic logic [PA_W-1:0] slot_addr(input logic [PA_W-1:0] base,
                                                  input logic [1:0] lvl);
        logic [8:0] idx;
        int sh;
        sh = 39 - 9 * int'(lvl);
        idx = 9'(walk_vaddr >> sh);
        return (base & FRAME_MASK) + {40'b0, idx, 3'b0};
    endfunction

    function automatic void walk_step(input t_in_item it);
        t_out_item r;
        logic [VA_W-1:0] offmask;
        logic big;
        r = '0;
        big = it.read_data[SIZE_BIT];
        if (it.action == ACT_TRANSLATE) begin
            // a new request is ignored while a walk is open
            if (!walk_open) begin
                walk_vaddr = it.virt_addr;
                walk_depth = LVL_TOP;
                walk_open = 1'b1;
                r.kind = KIND_READ;
                r.read_address = slot_addr(root_base, LVL_TOP);
                walker_replies.push_back(r);
            end
        end else if (walk_open) begin
            if (it.read_data == '0) begin
                r.kind = KIND_DONE;
                r.fault = 1'b1;
                r.fault_level = walk_depth;
                walk_open = 1'b0;
                walk_depth = LVL_TOP;
            end else if ((walk_depth == LVL_1G && big) || (walk_depth == LVL_2M && big)
                         || walk_depth == LVL_LEAF) begin
                if (walk_depth == LVL_1G)
                    offmask = OFFSET_1G;
                else if (walk_depth == LVL_2M)
                    offmask = OFFSET_2M;
                else
                    offmask = OFFSET_4K;
                r.kind = KIND_DONE;
                r.physical_address = (it.read_data[PA_W-1:0] & FRAME_MASK)
                                     + {4'b0, walk_vaddr & offmask};
                walk_open = 1'b0;
                walk_depth = LVL_TOP;
            end else begin
                walk_depth = walk_depth + 2'd1;
                r.kind = KIND_READ;
                r.read_address = slot_addr(it.read_data[PA_W-1:0], walk_depth);
            end
            walker_replies.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            root_base = '0;
            walk_open = 1'b0;
            walk_depth = LVL_TOP;
            walk_vaddr = '0;
            walker_replies.delete();
        end else begin
            // results leave only after their cause is registered, so check them first
            if (i_out_valid && !i_out_stall) begin
                if (walker_replies.size() == 0) begin
                    $error("unexpected result transaction: %p", i_out_item);
                    o_fail_count++;
                end else begin
                    want = walker_replies.pop_front();
                    check_field("kind", 64'(want.kind), 64'(i_out_item.kind));
                    check_field("read_address", 64'(want.read_address),
                                64'(i_out_item.read_address));
                    check_field("physical_address", 64'(want.physical_address),
                                64'(i_out_item.physical_address));
                    check_field("fault", 64'(want.fault), 64'(i_out_item.fault));
                    check_field("fault_level", 64'(want.fault_level),
                                64'(i_out_item.fault_level));
                end
            end
            // a root write lands after the edge, so a request taken at the
            // same edge still sees the old base
            if (i_in_valid && !i_in_stall)
                walk_step(i_in_item);
            if (i_cfg_valid && i_cfg_ready)
                root_base = i_cfg_data;
        end
        o_pending = walker_replies.size();
    end

endmodule

@@ sim/page_table_walker_tb.sv @@
module page_table_walker_tb;
    import ptw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // How a generated walk terminates
    typedef enum logic [1:0] {
        WALK_FAULT,
        WALK_1G,
        WALK_2M,
        WALK_4K
    } t_walk_end;

    localparam int SETTLE_CYCLES = 4;      // output reg + skid, with margin
    localparam int HOLD_CYCLES   = 300;    // long receiver back-pressure burst
    localparam int PHASE_ITEMS   = 290;    // walk transactions per random phase
    localparam int CYCLE_LIMIT   = 200000; // watchdog, far above a slow clean run

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_in_item        in_item = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_item       out_item;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [PA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Idle rates in percent; the sender's is read only by the stimulus process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Toggling hold_kick asks the receiver for one long hold-off
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    page_table_walker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ptw_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stall at the current rate, or a long hold-off when kicked.
    // While held off the walker fills its output and skid registers and must
    // push back on the input channel.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one input transaction and hold it until it is taken.
    // Each cycle in front of it is idle at the sender's rate.
    task automatic send_item(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_translate(input logic [VA_W-1:0] va);
        t_in_item it;
        it.action = ACT_TRANSLATE;
        it.virt_addr = va;
        it.read_data = {$urandom, $urandom};   // ignored on requests
        send_item(it);
    endtask

    task automatic send_entry(input logic [PTE_W-1:0] pte);
        t_in_item it;
        it.action = ACT_RESPONSE;
        it.virt_addr = VA_W'({$urandom, $urandom});   // ignored on responses
        it.read_data = pte;
        send_item(it);
    endtask

    // Nonzero table entry with the page-size bit forced
    function automatic logic [PTE_W-1:0] make_entry(input bit size, input bit ones);
        logic [PTE_W-1:0] e;
        e = ones ? '1 : {$urandom, $urandom};
        e[SIZE_BIT] = size;
        if (e == '0)
            e[12] = 1'b1;
        return e;
    endfunction

    // One well-formed walk: a translate, then one entry per level down to the
    // chosen end. With noise a stray response goes in while idle and a second
    // translate lands mid-walk; the walker must drop both.
    // n returns the number of walk transactions, noise not counted.
    task automatic run_walk(input logic [VA_W-1:0] va, input t_walk_end how,
                            input logic [1:0] fault_lvl, input bit noisy,
                            input bit ones, output int n);
        logic [1:0]       last;
        logic [PTE_W-1:0] pte;
        int               noise_at;
        case (how)
            WALK_FAULT: last = fault_lvl;
            WALK_1G:    last = LVL_1G;
            WALK_2M:    last = LVL_2M;
            default:    last = LVL_LEAF;
        endcase
        noise_at = $urandom_range(int'(last));
        if (noisy)
            send_entry(($urandom_range(3) == 0) ? '0 : {$urandom, $urandom});
        send_translate(va);
        for (int lvl = 0; lvl <= int'(last); lvl++) begin
            if (noisy && lvl == noise_at)
                send_translate(VA_W'({$urandom, $urandom}));
            if (how == WALK_FAULT && lvl == int'(last))
                pte = '0;
            else if (how != WALK_4K && lvl == int'(last))
                pte = make_entry(1'b1, ones);           // 1 GiB or 2 MiB page
            else if (lvl == int'(LVL_1G) || lvl == int'(LVL_2M))
                pte = make_entry(1'b0, ones);           // descend
            else
                pte = make_entry(ones ? 1'b1 : 1'($urandom_range(1)), ones);
            send_entry(pte);
        end
        n = int'(last) + 2;
    endtask

    // Let every owed result drain, then let the output and skid registers settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [PA_W-1:0] base);
        cfg_valid <= 1'b1;
        cfg_data <= base;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [PA_W-1:0] root, input int send_pct,
                             input int recv_pct, input bit squeeze);
        int        sent;
        int        n;
        int        pick;
        t_walk_end how;
        drain();
        write_root(root);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        if (squeeze)
            hold_kick <= ~hold_kick;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 15)
                how = WALK_FAULT;
            else if (pick < 35)
                how = WALK_1G;
            else if (pick < 60)
                how = WALK_2M;
            else
                how = WALK_4K;
            run_walk(VA_W'({$urandom, $urandom}), how, 2'($urandom_range(3)),
                     $urandom_range(99) < 15, 1'b0, n);
            sent += n;
        end
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: response while idle, then a walk on the reset root base
        // that faults right at the top level.
        send_entry('1);
        run_walk('0, WALK_FAULT, LVL_TOP, 1'b0, 1'b0, n);

        // Root base all ones: address sums reach the top of the 52-bit space.
        // All-ones entries keep the size bit at top and leaf, where it is
        // ignored; the first walk also carries a translate while busy.
        drain();
        write_root('1);
        run_walk('1, WALK_1G, LVL_TOP, 1'b1, 1'b1, n);
        run_walk('1, WALK_4K, LVL_TOP, 1'b0, 1'b1, n);
        run_walk(VA_W'({$urandom, $urandom}), WALK_2M, LVL_TOP, 1'b0, 1'b0, n);
        run_walk(VA_W'({$urandom, $urandom}), WALK_FAULT, LVL_2M, 1'b0, 1'b0, n);
        run_walk(VA_W'({$urandom, $urandom}), WALK_FAULT, LVL_LEAF, 1'b0, 1'b0, n);

        // Random walks: receiver-heavy idling, then sender-heavy, then none
        // with one long receiver hold-off.
        run_phase('0, 34, 45, 1'b0);
        run_phase(PA_W'({$urandom, $urandom}), 45, 34, 1'b0);
        run_phase(PA_W'({$urandom, $urandom}), 0, 0, 1'b1);

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ptw_pkg.sv
rtl/ptw_core.sv
rtl/ptw_out_buf.sv
rtl/page_table_walker.sv
sim/ptw_checker.sv
sim/page_table_walker_tb.sv
